// ===== design/atrp_pkg.sv =====
// shared types, constants and helper functions for the accelerometer tilt block
// no dependencies; imported by every atrp module and the top level
package atrp_pkg;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int TAB_LEN          = 24;

    localparam int GUARD_BITS = 8;
    localparam int ACC_W      = 26;
    localparam int GAIN_W     = 16;
    localparam int RND_SHIFT  = 8;
    localparam int RND_W      = ACC_W + 1 - RND_SHIFT;
    localparam int ROLL_W     = 17;
    localparam int PITCH_W    = 16;

    localparam logic signed [ACC_W-1:0]  DEG180_Q16   = ACC_W'(11796480);
    localparam logic        [GAIN_W-1:0] INV_GAIN_Q16 = GAIN_W'(39797);
    localparam logic signed [RND_W-1:0]  ROLL_LIM     = RND_W'(46080);
    localparam logic signed [RND_W-1:0]  PITCH_LIM    = RND_W'(23040);

    typedef struct packed {
        logic valid;
        logic skip;
    } ctl_t;

    // atan(2^-i) in degrees * 2^16
    function automatic logic signed [ACC_W-1:0] atan_q16(input int idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:       v = ACC_W'(2949120);
            1:       v = ACC_W'(1740967);
            2:       v = ACC_W'(919879);
            3:       v = ACC_W'(466945);
            4:       v = ACC_W'(234379);
            5:       v = ACC_W'(117304);
            6:       v = ACC_W'(58666);
            7:       v = ACC_W'(29335);
            8:       v = ACC_W'(14668);
            9:       v = ACC_W'(7334);
            10:      v = ACC_W'(3667);
            11:      v = ACC_W'(1833);
            12:      v = ACC_W'(917);
            13:      v = ACC_W'(458);
            14:      v = ACC_W'(229);
            15:      v = ACC_W'(115);
            16:      v = ACC_W'(57);
            17:      v = ACC_W'(29);
            18:      v = ACC_W'(14);
            19:      v = ACC_W'(7);
            20:      v = ACC_W'(4);
            21:      v = ACC_W'(2);
            22:      v = ACC_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // round half up to 1/256 degree, then clamp to +-lim
    function automatic logic signed [RND_W-1:0] round_clamp(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [RND_W-1:0] lim
    );
        logic signed [ACC_W:0]   sum;
        logic signed [RND_W-1:0] r;
        sum = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (RND_SHIFT - 1));
        r   = sum[ACC_W:RND_SHIFT];
        if (r > lim)
        begin
            r = lim;
        end
        else if (r < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

// ===== design/atrp_step.sv =====
// one registered cordic vectoring micro-rotation with sideband
// depends on atrp_pkg
module atrp_step
    import atrp_pkg::*;
#(
    parameter int W      = DEF_SAMPLE_BITS + 11,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = DEF_SAMPLE_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  ctl_t                     ctl_in,
    input  logic signed [W-1:0]      px_in,
    input  logic signed [W-1:0]      py_in,
    input  logic signed [ACC_W-1:0]  acc_in,
    input  logic        [SIDE_W-1:0] side_in,
    output ctl_t                     ctl_out,
    output logic signed [W-1:0]      px_out,
    output logic signed [W-1:0]      py_out,
    output logic signed [ACC_W-1:0]  acc_out,
    output logic        [SIDE_W-1:0] side_out
);

    localparam logic signed [ACC_W-1:0] ANGLE = atan_q16(SHIFT);

    ctl_t                    ctl_reg;
    logic signed [W-1:0]     px_reg,  px_next;
    logic signed [W-1:0]     py_reg,  py_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [SIDE_W-1:0]       side_reg;
    logic signed [W-1:0]     dx;
    logic signed [W-1:0]     dy;

    assign dx = py_in >>> SHIFT;
    assign dy = px_in >>> SHIFT;

    always_comb
    begin
        if (ctl_in.skip)
        begin
            px_next  = px_in;
            py_next  = py_in;
            acc_next = acc_in;
        end
        else if (!py_in[W-1])
        begin
            px_next  = px_in + dx;
            py_next  = py_in - dy;
            acc_next = acc_in + ANGLE;
        end
        else
        begin
            px_next  = px_in - dx;
            py_next  = py_in + dy;
            acc_next = acc_in - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            acc_reg  <= acc_next;
            side_reg <= side_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign px_out   = px_reg;
    assign py_out   = py_reg;
    assign acc_out  = acc_reg;
    assign side_out = side_reg;

endmodule

// ===== design/atrp_vec.sv =====
// four-quadrant atan2 by pipelined cordic vectoring: prep stage plus one stage per step
// depends on atrp_pkg and atrp_step
module atrp_vec
    import atrp_pkg::*;
#(
    parameter int W      = DEF_SAMPLE_BITS + 11,
    parameter int STEPS  = DEF_CORDIC_STEPS,
    parameter int SIDE_W = DEF_SAMPLE_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     valid_in,
    input  logic signed [W-1:0]      num,
    input  logic signed [W-1:0]      den,
    input  logic        [SIDE_W-1:0] side_in,
    output logic                     valid_out,
    output logic signed [W-1:0]      mag,
    output logic signed [ACC_W-1:0]  angle,
    output logic        [SIDE_W-1:0] side_out
);

    ctl_t                    ctl_pipe  [0:STEPS];
    logic signed [W-1:0]     px_pipe   [0:STEPS];
    logic signed [W-1:0]     py_pipe   [0:STEPS];
    logic signed [ACC_W-1:0] acc_pipe  [0:STEPS];
    logic [SIDE_W-1:0]       side_pipe [0:STEPS];

    ctl_t                    ctl_reg, ctl_next;
    logic signed [W-1:0]     px_reg,  px_next;
    logic signed [W-1:0]     py_reg,  py_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [SIDE_W-1:0]       side_reg;

    // fold left half-plane into the right, zero numerator bypasses the rotations
    always_comb
    begin
        ctl_next.valid = valid_in;
        ctl_next.skip  = 1'b0;
        px_next        = den;
        py_next        = num;
        acc_next       = '0;
        if (num == '0)
        begin
            ctl_next.skip = 1'b1;
            py_next       = '0;
            if (den[W-1])
            begin
                px_next  = -den;
                acc_next = DEG180_Q16;
            end
        end
        else if (den[W-1])
        begin
            px_next  = -den;
            py_next  = -num;
            acc_next = num[W-1] ? -DEG180_Q16 : DEG180_Q16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            acc_reg  <= acc_next;
            side_reg <= side_in;
        end
    end

    assign ctl_pipe[0]  = ctl_reg;
    assign px_pipe[0]   = px_reg;
    assign py_pipe[0]   = py_reg;
    assign acc_pipe[0]  = acc_reg;
    assign side_pipe[0] = side_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        atrp_step #(
            .W      (W),
            .SHIFT  (i),
            .SIDE_W (SIDE_W)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (ctl_pipe[i]),
            .px_in    (px_pipe[i]),
            .py_in    (py_pipe[i]),
            .acc_in   (acc_pipe[i]),
            .side_in  (side_pipe[i]),
            .ctl_out  (ctl_pipe[i+1]),
            .px_out   (px_pipe[i+1]),
            .py_out   (py_pipe[i+1]),
            .acc_out  (acc_pipe[i+1]),
            .side_out (side_pipe[i+1])
        );
    end

    assign valid_out = ctl_pipe[STEPS].valid;
    assign mag       = px_pipe[STEPS];
    assign angle     = acc_pipe[STEPS];
    assign side_out  = side_pipe[STEPS];

endmodule

// ===== design/atrp_gain.sv =====
// gain correction of the (x, z) magnitude and set-up of the pitch vector
// depends on atrp_pkg
module atrp_gain
    import atrp_pkg::*;
#(
    parameter int W  = DEF_SAMPLE_BITS + 11,
    parameter int SB = DEF_SAMPLE_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid_in,
    input  logic signed [W-1:0]     mag_in,
    input  logic signed [SB-1:0]    ay_in,
    input  logic signed [ACC_W-1:0] roll_in,
    output logic                    valid_out,
    output logic signed [W-1:0]     num,
    output logic signed [W-1:0]     den,
    output logic signed [ACC_W-1:0] roll_out
);

    logic                    valid_reg;
    logic signed [W-1:0]     num_reg, num_next;
    logic signed [W-1:0]     den_reg, den_next;
    logic signed [ACC_W-1:0] roll_reg;
    logic [W-2:0]            mag_pos;
    logic [W-2+GAIN_W:0]     prod;
    logic signed [W-1:0]     ay_scaled;

    assign ay_scaled = {{(W-SB-GUARD_BITS){ay_in[SB-1]}}, ay_in, {GUARD_BITS{1'b0}}};
    assign mag_pos   = mag_in[W-1] ? '0 : mag_in[W-2:0];
    assign prod      = mag_pos * INV_GAIN_Q16;
    assign num_next  = -ay_scaled;
    assign den_next  = {1'b0, prod[W-2+GAIN_W:GAIN_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            roll_reg <= roll_in;
        end
    end

    assign valid_out = valid_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign roll_out  = roll_reg;

endmodule

// ===== design/atrp_out.sv =====
// rounding and clamping of both angles, output register and skid register
// depends on atrp_pkg
module atrp_out
    import atrp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      tail_valid,
    input  logic signed [ACC_W-1:0]   roll_acc,
    input  logic signed [ACC_W-1:0]   pitch_acc,
    input  logic                      out_stall,
    output logic                      pipe_en,
    output logic                      out_valid,
    output logic signed [ROLL_W-1:0]  roll_deg,
    output logic signed [PITCH_W-1:0] pitch_deg
);

    logic                      out_valid_reg;
    logic                      skid_valid_reg;
    logic signed [ROLL_W-1:0]  roll_reg,  skid_roll_reg;
    logic signed [PITCH_W-1:0] pitch_reg, skid_pitch_reg;
    logic signed [RND_W-1:0]   roll_rnd;
    logic signed [RND_W-1:0]   pitch_rnd;
    logic signed [ROLL_W-1:0]  roll_next;
    logic signed [PITCH_W-1:0] pitch_next;
    logic                      out_free;

    assign roll_rnd   = round_clamp(roll_acc, ROLL_LIM);
    assign pitch_rnd  = round_clamp(pitch_acc, PITCH_LIM);
    assign roll_next  = roll_rnd[ROLL_W-1:0];
    assign pitch_next = pitch_rnd[PITCH_W-1:0];
    assign out_free   = !out_valid_reg || !out_stall;
    assign pipe_en    = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                skid_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
        end
        else if (tail_valid)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                roll_reg  <= skid_roll_reg;
                pitch_reg <= skid_pitch_reg;
            end
        end
        else if (tail_valid)
        begin
            if (out_free)
            begin
                roll_reg  <= roll_next;
                pitch_reg <= pitch_next;
            end
            else
            begin
                skid_roll_reg  <= roll_next;
                skid_pitch_reg <= pitch_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign roll_deg  = roll_reg;
    assign pitch_deg = pitch_reg;

endmodule

// ===== design/accel_tilt_roll_pitch.sv =====
// Accelerometer tilt: roll = atan2(x, z) over the full circle and
// pitch = atan2(-y, |(x, z)|) within +-90 degrees, both in 1/256 degree.
// Each sample runs through a fully pipelined CORDIC: a prep stage and one
// register stage per micro-rotation for roll, a gain-correction multiply stage,
// the same for pitch, and a rounding output stage. A sample is taken every
// cycle unless the input is stalled. Downstream stall is absorbed by one skid
// register, so input stalls only once both the output and skid registers are
// full. All-zero samples give zero angles.
// depends on atrp_pkg, atrp_vec, atrp_step, atrp_gain, atrp_out
module accel_tilt_roll_pitch
    import atrp_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] accel_x,
    input  logic signed [SAMPLE_BITS-1:0] accel_y,
    input  logic signed [SAMPLE_BITS-1:0] accel_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [ROLL_W-1:0]      roll_deg,
    output logic signed [PITCH_W-1:0]     pitch_deg
);

    localparam int W     = SAMPLE_BITS + GUARD_BITS + 3;
    localparam int STEPS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

    logic                          pipe_en;
    logic signed [W-1:0]           ax_scaled;
    logic signed [W-1:0]           az_scaled;

    logic                          roll_valid;
    logic signed [W-1:0]           roll_mag;
    logic signed [ACC_W-1:0]       roll_angle;
    logic signed [SAMPLE_BITS-1:0] roll_ay;

    logic                          gain_valid;
    logic signed [W-1:0]           gain_num;
    logic signed [W-1:0]           gain_den;
    logic signed [ACC_W-1:0]       gain_roll;

    logic                          pitch_valid;
    logic signed [W-1:0]           pitch_mag;
    logic signed [ACC_W-1:0]       pitch_angle;
    logic signed [ACC_W-1:0]       pitch_roll;

    assign ax_scaled = {{(W-SAMPLE_BITS-GUARD_BITS){accel_x[SAMPLE_BITS-1]}},
                        accel_x, {GUARD_BITS{1'b0}}};
    assign az_scaled = {{(W-SAMPLE_BITS-GUARD_BITS){accel_z[SAMPLE_BITS-1]}},
                        accel_z, {GUARD_BITS{1'b0}}};
    assign in_stall  = !pipe_en;

    atrp_vec #(
        .W      (W),
        .STEPS  (STEPS),
        .SIDE_W (SAMPLE_BITS)
    ) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .valid_in  (in_valid),
        .num       (ax_scaled),
        .den       (az_scaled),
        .side_in   (accel_y),
        .valid_out (roll_valid),
        .mag       (roll_mag),
        .angle     (roll_angle),
        .side_out  (roll_ay)
    );

    atrp_gain #(
        .W  (W),
        .SB (SAMPLE_BITS)
    ) u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .valid_in  (roll_valid),
        .mag_in    (roll_mag),
        .ay_in     (roll_ay),
        .roll_in   (roll_angle),
        .valid_out (gain_valid),
        .num       (gain_num),
        .den       (gain_den),
        .roll_out  (gain_roll)
    );

    atrp_vec #(
        .W      (W),
        .STEPS  (STEPS),
        .SIDE_W (ACC_W)
    ) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .valid_in  (gain_valid),
        .num       (gain_num),
        .den       (gain_den),
        .side_in   (gain_roll),
        .valid_out (pitch_valid),
        .mag       (pitch_mag),
        .angle     (pitch_angle),
        .side_out  (pitch_roll)
    );

    atrp_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail_valid (pitch_valid && !pitch_mag[W-1] || pitch_valid),
        .roll_acc   (pitch_roll),
        .pitch_acc  (pitch_angle),
        .out_stall  (out_stall),
        .pipe_en    (pipe_en),
        .out_valid  (out_valid),
        .roll_deg   (roll_deg),
        .pitch_deg  (pitch_deg)
    );

endmodule

// ===== verif/tb_accel_tilt_roll_pitch.sv =====
// self-checking testbench for accel_tilt_roll_pitch: directed corner samples, then random
// samples, some under random valid/stall idling, checked by an in-bench cordic predictor
// depends on atrp_pkg and the accel_tilt_roll_pitch rtl
module tb_accel_tilt_roll_pitch
    import atrp_pkg::*;
();

    localparam int    STEPS       = DEF_CORDIC_STEPS;
    localparam int    ATAN_N      = 24;
    localparam int    LATENCY     = 2 * STEPS + 4;
    localparam longint HALF_TURN  = 64'sd11796480;
    localparam longint GAIN_FIX   = 64'sd39797;
    localparam longint ROLL_MAX   = 64'sd46080;
    localparam longint PITCH_MAX  = 64'sd23040;
    localparam int    DIR_N       = 23;

    localparam longint ATAN_Q16 [ATAN_N] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
    } tilt_t;

    typedef struct packed {
        logic signed [15:0]        x;
        logic signed [15:0]        y;
        logic signed [15:0]        z;
        bit                        known;
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
    } dir_row_t;

    // rows with known set carry their angles typed in; the rest use the predictor
    dir_row_t dir_rows [DIR_N] = '{
        '{0, 0, 0, 1'b1, 0, 0},
        '{0, 0, 32767, 1'b1, 0, 0},
        '{0, 0, -32768, 1'b1, 46080, 0},
        '{0, 0, 1, 1'b1, 0, 0},
        '{0, 0, -1, 1'b1, 46080, 0},
        '{0, 32767, 0, 1'b0, 0, 0},
        '{0, -32768, 0, 1'b0, 0, 0},
        '{0, 1, 0, 1'b0, 0, 0},
        '{0, -1, 0, 1'b0, 0, 0},
        '{100, 0, -32768, 1'b0, 0, 0},
        '{-100, 0, -32768, 1'b0, 0, 0},
        '{1, 0, -32768, 1'b0, 0, 0},
        '{-1, 0, -32768, 1'b0, 0, 0},
        '{32767, 32767, 32767, 1'b0, 0, 0},
        '{-32768, -32768, -32768, 1'b0, 0, 0},
        '{32767, -32768, -32768, 1'b0, 0, 0},
        '{-32768, 32767, 32767, 1'b0, 0, 0},
        '{32767, 0, 0, 1'b0, 0, 0},
        '{-32768, 0, 0, 1'b0, 0, 0},
        '{-32768, -32768, 0, 1'b0, 0, 0},
        '{1, 1, 1, 1'b0, 0, 0},
        '{-1, -1, -1, 1'b0, 0, 0},
        '{0, -32768, 1, 1'b0, 0, 0}
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic signed [15:0]        accel_x   = '0;
    logic signed [15:0]        accel_y   = '0;
    logic signed [15:0]        accel_z   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [ROLL_W-1:0]  roll_deg;
    logic signed [PITCH_W-1:0] pitch_deg;

    tilt_t tilt_q [$];
    int    errors       = 0;
    int    sent         = 0;
    int    checked      = 0;
    int    blocked      = 0;
    int    long_holds   = 0;
    bit    tx_idle_on   = 1'b1;
    bit    rx_idle_on   = 1'b1;
    bit    hold_req     = 1'b0;

    accel_tilt_roll_pitch i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .roll_deg  (roll_deg),
        .pitch_deg (pitch_deg)
    );

    always #4 clk = ~clk;

    // vectoring cordic, angle in degrees * 2^16, scaled length in len
    function automatic longint vec_angle(input longint num, input longint den,
                                         output longint len);
        longint acc;
        longint px;
        longint py;
        longint dx;
        longint dy;
        acc = 0;
        px  = den;
        py  = num;
        if (num == 0)
        begin
            len = (den < 0) ? -den : den;
            return (den < 0) ? HALF_TURN : 0;
        end
        if (den < 0)
        begin
            acc = (num >= 0) ? HALF_TURN : -HALF_TURN;
            px  = -den;
            py  = -num;
        end
        for (int i = 0; i < STEPS && i < ATAN_N; i++)
        begin
            dx = py >>> i;
            dy = px >>> i;
            if (py >= 0)
            begin
                px  = px + dx;
                py  = py - dy;
                acc = acc + ATAN_Q16[i];
            end
            else
            begin
                px  = px - dx;
                py  = py + dy;
                acc = acc - ATAN_Q16[i];
            end
        end
        len = px;
        return acc;
    endfunction

    function automatic longint deg_round(input longint acc, input longint lim);
        longint r;
        r = (acc + 128) >>> 8;
        if (r > lim)
        begin
            r = lim;
        end
        if (r < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

    function automatic tilt_t tilt_angles(input logic signed [15:0] x,
                                          input logic signed [15:0] y,
                                          input logic signed [15:0] z);
        tilt_t  t;
        longint ax;
        longint ay;
        longint az;
        longint len;
        longint scratch;
        longint racc;
        longint pacc;
        ax = longint'(x) * 256;
        ay = longint'(y) * 256;
        az = longint'(z) * 256;
        t  = '0;
        if (ax != 0 || ay != 0 || az != 0)
        begin
            racc = vec_angle(ax, az, len);
            if (len < 0)
            begin
                len = 0;
            end
            len     = (len * GAIN_FIX) >>> 16;
            pacc    = vec_angle(-ay, len, scratch);
            t.roll  = ROLL_W'(deg_round(racc, ROLL_MAX));
            t.pitch = PITCH_W'(deg_round(pacc, PITCH_MAX));
        end
        return t;
    endfunction

    task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic signed [15:0] z, input tilt_t want);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        accel_x  <= x;
        accel_y  <= y;
        accel_z  <= z;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        tilt_q.push_back(want);
        sent++;
    endtask

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(0, 5))
            0:       return -16'sd32768;
            1:       return -16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_small();
        return 16'($signed($urandom_range(0, 8)) - 4);
    endfunction

    task automatic random_samples(input int count);
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        repeat (count)
        begin
            x = 16'($urandom);
            y = 16'($urandom);
            z = 16'($urandom);
            case ($urandom_range(0, 11))
                4:
                begin
                    x = pick_small();
                    y = pick_small();
                    z = pick_small();
                end
                5:
                begin
                    if ($urandom_range(0, 1))
                    begin
                        x = '0;
                    end
                    else
                    begin
                        z = '0;
                    end
                end
                6:
                begin
                    x = '0;
                    z = '0;
                end
                7:
                begin
                    x = pick_extreme();
                    y = pick_extreme();
                    z = pick_extreme();
                end
                8:
                begin
                    x = pick_small();
                    y = pick_small();
                end
                9:
                begin
                    x = ($urandom_range(0, 3) == 0) ? 16'sd0 : x;
                    y = '0;
                    z = pick_extreme();
                end
                default:
                begin
                end
            endcase
            send_sample(x, y, z, tilt_angles(x, y, z));
        end
    endtask

    task automatic drain();
        while (tilt_q.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        tilt_t want;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < DIR_N; n++)
        begin
            want = dir_rows[n].known ? tilt_t'{dir_rows[n].roll, dir_rows[n].pitch}
                                     : tilt_angles(dir_rows[n].x, dir_rows[n].y,
                                                   dir_rows[n].z);
            send_sample(dir_rows[n].x, dir_rows[n].y, dir_rows[n].z, want);
        end
        in_valid <= 1'b0;
        drain();

        random_samples(300);
        in_valid <= 1'b0;
        drain();

        // back-to-back requests against a long output hold-off
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
        random_samples(150);

        rx_idle_on = 1'b0;
        random_samples(150);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        random_samples(300);
        in_valid <= 1'b0;

        drain();
        repeat (LATENCY + 10) @(posedge clk);

        $display("%0d requests (%0d corner cases), %0d results checked", sent, DIR_N, checked);
        $display("input stalled for %0d cycles, %0d long output hold-off(s)",
                 blocked, long_holds);
        if (errors == 0)
        begin
            $display("accel_tilt_roll_pitch verification clean");
        end
        else
        begin
            $display("accel_tilt_roll_pitch verification failed");
        end
        $finish;
    end

    initial
    begin
        int k;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                k          = 300;
                hold_req   = 1'b0;
                long_holds++;
            end
            else
            begin
                k = rx_idle_on ? $urandom_range(0, 15) : 0;
            end
            if (k > 0)
            begin
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        tilt_t want;
        if (rst_n && in_valid && in_stall)
        begin
            blocked++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (tilt_q.size() == 0)
            begin
                $error("result with no request pending: roll_deg %0d pitch_deg %0d",
                       roll_deg, pitch_deg);
                errors++;
            end
            else
            begin
                want = tilt_q.pop_front();
                checked++;
                if (roll_deg !== want.roll)
                begin
                    $error("roll_deg expected %0d actual %0d", want.roll, roll_deg);
                    errors++;
                end
                if (pitch_deg !== want.pitch)
                begin
                    $error("pitch_deg expected %0d actual %0d", want.pitch, pitch_deg);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("accel_tilt_roll_pitch verification failed");
        $finish;
    end

endmodule
